@@ rtl/rfc_pkg.sv @@
// Package for the rational fraction compare block: widths, micro-op codes,
// sequencer status/control types and the microcode program.
// No dependencies.
package rfc_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int FIELD_WIDTH = 63;
   localparam int OPW = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
   localparam int CNT_WIDTH = $clog2(OPW);
   localparam int PC_WIDTH = 4;

   typedef logic [OPW-1:0] value_type;
   typedef logic [CNT_WIDTH-1:0] count_type;
   typedef logic [PC_WIDTH-1:0] pc_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SWAP,
      OP_OUT_BAD,
      OP_OUT_QUO,
      OP_OUT_REM
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_BAD_DEN,
      COND_DIV_BUSY,
      COND_QUO_NE,
      COND_REM_ZERO,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   tgt_true;
      pc_type   tgt_false;
   } uword_type;

   typedef struct packed {
      logic req;
      logic bad_den;
      logic div_busy;
      logic quo_ne;
      logic rem_zero;
      logic out_free;
   } status_type;

   localparam pc_type PC_IDLE     = 4'd0;
   localparam pc_type PC_CHECK    = 4'd1;
   localparam pc_type PC_DIV_INIT = 4'd2;
   localparam pc_type PC_DIV_STEP = 4'd3;
   localparam pc_type PC_QUO_CMP  = 4'd4;
   localparam pc_type PC_REM_CHK  = 4'd5;
   localparam pc_type PC_SWAP     = 4'd6;
   localparam pc_type PC_OUT_BAD  = 4'd7;
   localparam pc_type PC_OUT_QUO  = 4'd8;
   localparam pc_type PC_OUT_REM  = 4'd9;

   function automatic uword_type ucode(input pc_type pc);
      uword_type w;
      unique case (pc)
         PC_IDLE:     w = '{OP_LOAD,     COND_REQ,      PC_CHECK,    PC_IDLE};
         PC_CHECK:    w = '{OP_NONE,     COND_BAD_DEN,  PC_OUT_BAD,  PC_DIV_INIT};
         PC_DIV_INIT: w = '{OP_DIV_INIT, COND_ALWAYS,   PC_DIV_STEP, PC_DIV_STEP};
         PC_DIV_STEP: w = '{OP_DIV_STEP, COND_DIV_BUSY, PC_DIV_STEP, PC_QUO_CMP};
         PC_QUO_CMP:  w = '{OP_NONE,     COND_QUO_NE,   PC_OUT_QUO,  PC_REM_CHK};
         PC_REM_CHK:  w = '{OP_NONE,     COND_REM_ZERO, PC_OUT_REM,  PC_SWAP};
         PC_SWAP:     w = '{OP_SWAP,     COND_ALWAYS,   PC_DIV_INIT, PC_DIV_INIT};
         PC_OUT_BAD:  w = '{OP_OUT_BAD,  COND_OUT_FREE, PC_IDLE,     PC_OUT_BAD};
         PC_OUT_QUO:  w = '{OP_OUT_QUO,  COND_OUT_FREE, PC_IDLE,     PC_OUT_QUO};
         PC_OUT_REM:  w = '{OP_OUT_REM,  COND_OUT_FREE, PC_IDLE,     PC_OUT_REM};
         default:     w = '{OP_NONE,     COND_ALWAYS,   PC_IDLE,     PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/rfc_divider.sv @@
// Restoring shift-subtract divider, one quotient bit per step.
// Depends on rfc_pkg.
module rfc_divider (
   input  logic              clock,
   input  logic              init,
   input  logic              step,
   input  rfc_pkg::value_type dividend,
   input  rfc_pkg::value_type divisor,
   output rfc_pkg::value_type quo,
   output rfc_pkg::value_type rem
);

   rfc_pkg::value_type quo_ff, quo_in;
   rfc_pkg::value_type rem_ff, rem_in;
   logic [rfc_pkg::OPW:0] part;

   always_comb begin
      part = {rem_ff, quo_ff[rfc_pkg::OPW-1]};
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (init) begin
         quo_in = dividend;
         rem_in = '0;
      end else if (step) begin
         if (part >= {1'b0, divisor}) begin
            rem_in = rfc_pkg::OPW'(part - {1'b0, divisor});
            quo_in = {quo_ff[rfc_pkg::OPW-2:0], 1'b1};
         end else begin
            rem_in = part[rfc_pkg::OPW-1:0];
            quo_in = {quo_ff[rfc_pkg::OPW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quo = quo_ff;
   assign rem = rem_ff;

endmodule

@@ rtl/rfc_datapath.sv @@
// Operand registers, two dividers, parity flag, step counter and result register.
// Depends on rfc_pkg and rfc_divider.
module rfc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  rfc_pkg::op_type     op,
   input  logic                req_valid,
   input  logic [62:0]         req_left_num,
   input  logic [62:0]         req_left_den,
   input  logic [62:0]         req_right_num,
   input  logic [62:0]         req_right_den,
   input  logic                rsp_stall,
   output rfc_pkg::status_type status,
   output logic                rsp_valid,
   output logic                rsp_is_less,
   output logic                rsp_bad_input
);

   rfc_pkg::value_type a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   rfc_pkg::value_type qa, ra, qc, rc;
   rfc_pkg::count_type cnt_ff, cnt_in;
   logic flip_ff, flip_in;
   logic valid_ff, valid_in;
   logic less_ff, less_in;
   logic bad_ff, bad_in;
   logic out_free, fire, raw;

   rfc_divider u_div_left (
      .clock    (clock),
      .init     (op == rfc_pkg::OP_DIV_INIT),
      .step     (op == rfc_pkg::OP_DIV_STEP),
      .dividend (a_ff),
      .divisor  (b_ff),
      .quo      (qa),
      .rem      (ra)
   );

   rfc_divider u_div_right (
      .clock    (clock),
      .init     (op == rfc_pkg::OP_DIV_INIT),
      .step     (op == rfc_pkg::OP_DIV_STEP),
      .dividend (c_ff),
      .divisor  (d_ff),
      .quo      (qc),
      .rem      (rc)
   );

   assign out_free = !valid_ff || !rsp_stall;
   assign raw = (ra == '0);

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      flip_in = flip_ff;
      less_in = less_ff;
      bad_in = bad_ff;
      valid_in = valid_ff && rsp_stall;
      fire = 1'b0;
      unique case (op)
         rfc_pkg::OP_LOAD: begin
            if (req_valid) begin
               a_in = req_left_num[rfc_pkg::OPW-1:0];
               b_in = req_left_den[rfc_pkg::OPW-1:0];
               c_in = req_right_num[rfc_pkg::OPW-1:0];
               d_in = req_right_den[rfc_pkg::OPW-1:0];
               flip_in = 1'b0;
            end
         end
         rfc_pkg::OP_DIV_INIT: cnt_in = rfc_pkg::CNT_WIDTH'(rfc_pkg::OPW - 1);
         rfc_pkg::OP_DIV_STEP: cnt_in = cnt_ff - 1'b1;
         rfc_pkg::OP_SWAP: begin
            a_in = b_ff;
            b_in = ra;
            c_in = d_ff;
            d_in = rc;
            flip_in = !flip_ff;
         end
         rfc_pkg::OP_OUT_BAD: begin
            fire = out_free;
            if (fire) begin
               less_in = 1'b0;
               bad_in = 1'b1;
            end
         end
         rfc_pkg::OP_OUT_QUO: begin
            fire = out_free;
            if (fire) begin
               less_in = flip_ff ? (qa > qc) : (qa < qc);
               bad_in = 1'b0;
            end
         end
         rfc_pkg::OP_OUT_REM: begin
            fire = out_free;
            if (fire) begin
               // both remainders zero: equal fractions
               less_in = (raw && rc == '0) ? 1'b0 : (flip_ff ? !raw : raw);
               bad_in = 1'b0;
            end
         end
         default: ;
      endcase
      if (fire) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      flip_ff <= flip_in;
      less_ff <= less_in;
      bad_ff <= bad_in;
   end

   always_comb begin
      status.req = req_valid;
      status.bad_den = (b_ff == '0) || (d_ff == '0);
      status.div_busy = (cnt_ff != '0);
      status.quo_ne = (qa != qc);
      status.rem_zero = (ra == '0) || (rc == '0);
      status.out_free = out_free;
   end

   assign rsp_valid = valid_ff;
   assign rsp_is_less = less_ff;
   assign rsp_bad_input = bad_ff;

endmodule

@@ rtl/rfc_sequencer.sv @@
// Microcode sequencer: program counter, control word fetch, conditional jumps.
// Depends on rfc_pkg (program table and types).
module rfc_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  rfc_pkg::status_type status,
   output rfc_pkg::op_type     op,
   output logic                idle
);

   rfc_pkg::pc_type pc_ff, pc_in;
   rfc_pkg::uword_type word;
   logic taken;

   always_comb begin
      word = rfc_pkg::ucode(pc_ff);
      unique case (word.cond)
         rfc_pkg::COND_ALWAYS:   taken = 1'b1;
         rfc_pkg::COND_REQ:      taken = status.req;
         rfc_pkg::COND_BAD_DEN:  taken = status.bad_den;
         rfc_pkg::COND_DIV_BUSY: taken = status.div_busy;
         rfc_pkg::COND_QUO_NE:   taken = status.quo_ne;
         rfc_pkg::COND_REM_ZERO: taken = status.rem_zero;
         rfc_pkg::COND_OUT_FREE: taken = status.out_free;
         default:                taken = 1'b1;
      endcase
      pc_in = taken ? word.tgt_true : word.tgt_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= rfc_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op = word.op;
   assign idle = (pc_ff == rfc_pkg::PC_IDLE);

endmodule

@@ rtl/rational_fraction_compare.sv @@
// A zero denominator goes from the check straight to the bad-input output;
// otherwise R continued-fraction rounds run (OPW = 63 quotient-bit steps of the
// divider pair each), plus the remainder check when a zero remainder decides.
// Requests are taken only when idle; R reaches about 90 on worst-case inputs.
// Reset (synchronous) returns the program counter to idle and drops rsp_valid.
// A new request is taken while a finished result waits on rsp_stall.
module rational_fraction_compare (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [62:0] req_left_num,
   input  logic [62:0] req_left_den,
   input  logic [62:0] req_right_num,
   input  logic [62:0] req_right_den,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_less,
   output logic        rsp_bad_input
);

   rfc_pkg::status_type status;
   rfc_pkg::op_type op;
   logic idle;

   rfc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op),
      .idle   (idle)
   );

   rfc_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .req_valid     (req_valid),
      .req_left_num  (req_left_num),
      .req_left_den  (req_left_den),
      .req_right_num (req_right_num),
      .req_right_den (req_right_den),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_is_less   (rsp_is_less),
      .rsp_bad_input (rsp_bad_input)
   );

   assign req_stall = !idle;

endmodule

@@ verif/rational_fraction_compare_tb.sv @@
// Testbench for rational_fraction_compare: predicts each verdict with a
// continued-fraction comparison and checks every result transfer in order.
// Depends on rfc_pkg and the rational_fraction_compare RTL.
`timescale 1ns / 100ps

module rational_fraction_compare_tb;

   localparam rfc_pkg::value_type MAXV = '1;
   localparam int unsigned STALL_LIMIT = 40000;

   typedef struct {
      logic is_less;
      logic bad_input;
   } verdict_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   rfc_pkg::value_type req_left_num;
   rfc_pkg::value_type req_left_den;
   rfc_pkg::value_type req_right_num;
   rfc_pkg::value_type req_right_den;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_is_less;
   logic               rsp_bad_input;

   verdict_type        pending_verdicts[$];
   rfc_pkg::value_type fib[0:92];
   bit                 idle_en;
   int unsigned        stall_left = 0;
   int unsigned        quiet_cycles = 0;
   int unsigned        mismatch_count = 0;

   rational_fraction_compare dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_num  (req_left_num),
      .req_left_den  (req_left_den),
      .req_right_num (req_right_num),
      .req_right_den (req_right_den),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_less   (rsp_is_less),
      .rsp_bad_input (rsp_bad_input)
   );

   always #5 clock = ~clock;

   function automatic logic cf_less_than(rfc_pkg::value_type a, rfc_pkg::value_type b,
                                         rfc_pkg::value_type c, rfc_pkg::value_type d);
      rfc_pkg::value_type qa;
      rfc_pkg::value_type qc;
      rfc_pkg::value_type t;
      logic               odd;
      odd = 1'b0;
      while (1) begin
         qa = a / b;
         qc = c / d;
         if (qa != qc)
            return odd ? (qa > qc) : (qa < qc);
         a = a % b;
         c = c % d;
         if (a == 0 && c == 0)
            return 1'b0;
         if (a == 0 || c == 0)
            return odd ? (a != 0) : (a == 0);
         t = a; a = b; b = t;
         t = c; c = d; d = t;
         odd = ~odd;
      end
   endfunction

   function automatic rfc_pkg::value_type rand_value(int unsigned w);
      logic [63:0] r;
      r = {$urandom, $urandom};
      if (w == 0)
         return '0;
      return rfc_pkg::value_type'(r >> (64 - w));
   endfunction

   task automatic issue_compare(input rfc_pkg::value_type ln, input rfc_pkg::value_type ld,
                                input rfc_pkg::value_type rn, input rfc_pkg::value_type rd);
      verdict_type v;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_left_num  <= ln;
      req_left_den  <= ld;
      req_right_num <= rn;
      req_right_den <= rd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      v.bad_input = (ld == 0 || rd == 0);
      v.is_less   = v.bad_input ? 1'b0 : cf_less_than(ln, ld, rn, rd);
      pending_verdicts.insert(pending_verdicts.size(), v);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic issue_wide_random;
      rfc_pkg::value_type ld;
      rfc_pkg::value_type rd;
      ld = ($urandom_range(0, 19) == 0) ? rfc_pkg::value_type'(0)
                                        : rand_value($urandom_range(1, 63));
      rd = ($urandom_range(0, 19) == 0) ? rfc_pkg::value_type'(0)
                                        : rand_value($urandom_range(1, 63));
      issue_compare(rand_value($urandom_range(0, 63)), ld,
                    rand_value($urandom_range(0, 63)), rd);
   endtask

   // a/b against a scaled copy of itself, optionally nudged by one or, if allowed, with d zeroed
   task automatic issue_close_pair(input bit allow_broken);
      int unsigned        w;
      rfc_pkg::value_type a, b, c, d, k;
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 14);
      a = rand_value(w);
      b = rand_value(w);
      if (b == 0)
         b = 1;
      k = rand_value($urandom_range(0, 62 - w));
      if (k == 0)
         k = 1;
      c = a * k;
      d = b * k;
      case ($urandom_range(0, 3))
         0: ;
         1: c = c + 1;
         2: c = (c != 0) ? c - 1 : c + 1;
         default: d = d + 1;
      endcase
      if (allow_broken && $urandom_range(0, 15) == 0)
         d = 0;
      if ($urandom_range(0, 1))
         issue_compare(a, b, c, d);
      else
         issue_compare(c, d, a, b);
   endtask

   task automatic test_directed_cases;
      issue_compare(5, 0, 3, 4);
      issue_compare(3, 4, 5, 0);
      issue_compare(0, 0, 0, 0);
      issue_compare(MAXV, 0, MAXV, MAXV);
      issue_compare(0, 1, 0, 1);
      issue_compare(0, MAXV, 0, 5);
      issue_compare(0, 1, 1, MAXV);
      issue_compare(1, MAXV, 0, 1);
      issue_compare(MAXV, 1, MAXV, 1);
      issue_compare(MAXV, MAXV, 1, 1);
      issue_compare(MAXV - 1, 1, MAXV, 1);
      issue_compare(1, MAXV, 1, MAXV - 1);
      issue_compare(3, 7, 6, 14);
      issue_compare(2, 1, 5, 2);
      issue_compare(5, 2, 2, 1);
      issue_compare(7, 3, 9, 4);
      issue_compare(9, 4, 7, 3);
      issue_compare(1, 2, 1, 3);
      issue_compare(MAXV, MAXV - 1, MAXV - 1, MAXV - 2);
      issue_compare(fib[92], fib[91], fib[91], fib[90]);
      issue_compare(fib[91], fib[90], fib[92], fib[91]);
   endtask

   task automatic test_wide_random;
      repeat (350) issue_wide_random();
   endtask

   task automatic test_near_equal;
      for (int i = 0; i < 800; i++) begin
         if (i == 400)
            drain_results();
         if ($urandom_range(0, 11) == 0)
            issue_wide_random();
         else
            issue_close_pair(1'b1);
      end
   endtask

   task automatic test_fibonacci_chains;
      int unsigned n;
      repeat (12) begin
         n = $urandom_range(40, 90);
         if ($urandom_range(0, 1))
            issue_compare(fib[n + 2], fib[n + 1], fib[n + 1], fib[n]);
         else
            issue_compare(fib[n], fib[n + 2], fib[n - 1], fib[n + 1]);
      end
   endtask

   task automatic test_back_to_back;
      idle_en = 1'b0;
      repeat (450) begin
         if ($urandom_range(0, 1))
            issue_wide_random();
         else
            issue_close_pair(1'b0);
      end
      req_valid <= 1'b0;
   endtask

   // result sink: random stall bursts
   always @(posedge clock) begin
      if (reset || !idle_en) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result transfer, is_less %0b bad_input %0b",
                     $time, rsp_is_less, rsp_bad_input);
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_is_less !== want.is_less) begin
               $display("%0t: is_less expected %0b, got %0b",
                        $time, want.is_less, rsp_is_less);
               mismatch_count++;
            end
            if (rsp_bad_input !== want.bad_input) begin
               $display("%0t: bad_input expected %0b, got %0b",
                        $time, want.bad_input, rsp_bad_input);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("[rational_fraction_compare] ERROR");
         $finish;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_left_num   = '0;
      req_left_den   = '0;
      req_right_num  = '0;
      req_right_den  = '0;
      idle_en        = 1'b1;
      fib[0] = 0;
      fib[1] = 1;
      for (int i = 2; i <= 92; i++)
         fib[i] = fib[i - 1] + fib[i - 2];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_wide_random();
      test_near_equal();
      test_fibonacci_chains();
      test_back_to_back();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("[rational_fraction_compare] OK");
      else
         $display("[rational_fraction_compare] ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rfc_pkg.sv
rtl/rfc_divider.sv
rtl/rfc_datapath.sv
rtl/rfc_sequencer.sv
rtl/rational_fraction_compare.sv
verif/rational_fraction_compare_tb.sv
